@@ sv/erfsb_pkg.sv @@
package erfsb_pkg;

    // Controller sequence
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_GO,
        ST_LD_WAIT,
        ST_POS_GO,
        ST_POS_WAIT,
        ST_T_GO,
        ST_T_WAIT,
        ST_ERF_WAIT,
        ST_TERM_GO,
        ST_TERM_WAIT,
        ST_DONE
    } t_state;

    // Configuration register indexes
    localparam logic [2:0] REG_SCALE   = 3'd0;
    localparam logic [2:0] REG_INV_R   = 3'd1;
    localparam logic [2:0] REG_BCOUNT  = 3'd2;
    localparam logic [2:0] REG_PSPACE  = 3'd3;
    localparam logic [2:0] REG_LOFFSET = 3'd4;
    localparam logic [2:0] REG_BSPACE  = 3'd5;

    // Serial multiplier widths
    localparam int MUL_AW = 48;
    localparam int MUL_BW = 32;
    localparam int MUL_PW = 68;

    typedef struct packed {
        logic                     start;
        logic signed [MUL_AW-1:0] a;
        logic [MUL_BW-1:0]        b;
        logic [5:0]               nbits;
        logic                     b_signed;
    } t_mul_req;

    // Error function table
    localparam int ERF_DEPTH = 1024;
    localparam int ERF_IW    = 10;
    localparam int SIX_Q16   = 393216;
    localparam logic [17:0] FACTOR_TWO = 18'd131072;
    localparam logic [16:0] ONE_Q16    = 17'd65536;

    localparam logic [16:0] ERF_KNOTS [25] = '{
        17'd0,     17'd18109, 17'd34111, 17'd46606, 17'd55227, 17'd60483,
        17'd63315, 17'd64663, 17'd65229, 17'd65440, 17'd65509, 17'd65529,
        17'd65535, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536,
        17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536,
        17'd65536
    };

    // One plus erf at the centre of bin j, Q2.16
    function automatic logic [17:0] f_erf_entry(input logic [ERF_IW-1:0] j);
        logic [ERF_IW:0] odd;
        logic [19:0]     off;
        logic            neg;
        logic [19:0]     ax;
        logic [4:0]      ki;
        logic [13:0]     fr;
        logic [16:0]     dk;
        logic [30:0]     pr;
        logic [16:0]     e;
        odd = {j, 1'b1};
        off = 20'((32'(odd) * 32'(SIX_Q16)) / ERF_DEPTH);
        neg = (off < 20'(SIX_Q16));
        ax  = neg ? (20'(SIX_Q16) - off) : (off - 20'(SIX_Q16));
        ki  = ax[18:14];
        fr  = ax[13:0];
        if (ki >= 5'd24) begin
            e = ERF_KNOTS[24];
        end else begin
            dk = ERF_KNOTS[ki + 5'd1] - ERF_KNOTS[ki];
            pr = 31'(dk) * 31'(fr);
            e  = ERF_KNOTS[ki] + 17'(pr >> 14);
        end
        return neg ? 18'(ONE_Q16 - e) : (18'(ONE_Q16) + 18'(e));
    endfunction

endpackage

@@ sv/erfsb_mul.sv @@
module erfsb_mul (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  erfsb_pkg::t_mul_req                    i_req,
    output logic                                   o_done,
    output logic signed [erfsb_pkg::MUL_PW-1:0]    o_prod
);
    import erfsb_pkg::*;

    logic signed [MUL_PW-1:0] r_a;
    logic signed [MUL_PW-1:0] r_acc;
    logic signed [MUL_PW-1:0] n_acc;
    logic [MUL_BW-1:0]        r_b;
    logic [5:0]               r_cnt;
    logic                     r_sgn;
    logic                     r_done;

    // Add or, on the sign bit of a signed multiplier, subtract the partial product
    always_comb begin
        if (r_b[0]) begin
            n_acc = (r_cnt == 6'd1 && r_sgn) ? (r_acc - r_a) : (r_acc + r_a);
        end else begin
            n_acc = r_acc;
        end
    end

    // Bit counter and done flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= i_req.nbits;
            end else if (r_cnt != 6'd0) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= MUL_PW'(i_req.a);
            r_b   <= i_req.b;
            r_sgn <= i_req.b_signed;
            r_acc <= '0;
        end else if (r_cnt != 6'd0) begin
            r_acc <= n_acc;
            r_a   <= r_a <<< 1;
            r_b   <= r_b >> 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

@@ sv/erfsb_erf.sv @@
module erfsb_erf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [45:0] i_t,
    output logic               o_done,
    output logic [17:0]        o_factor
);
    import erfsb_pkg::*;

    logic               w_hi;
    logic               w_mid;
    logic [45:0]        w_u;
    logic [11:0]        w_x;
    logic [27:0]        w_q;
    logic [ERF_IW-1:0]  w_idx;
    logic               r_v1;
    logic               r_v2;
    logic               r_hi;
    logic               r_mid;
    logic [ERF_IW-1:0]  r_idx;
    logic [17:0]        r_factor;

    // Classify t and find the table bin: floor((t + 393216) / 768) on the raw Q16 value, by a reciprocal of three
    always_comb begin
        w_hi  = (i_t > 46'sd393216);
        w_mid = (i_t > -46'sd393216);
        w_u   = 46'(i_t + 46'sd393216);
        w_x   = w_u[19:8];
        w_q   = 28'(w_x) * 28'd43691;
        w_idx = (w_q[27:17] >= 11'(ERF_DEPTH)) ? ERF_IW'(ERF_DEPTH - 1) : w_q[ERF_IW+16:17];
    end

    // Valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
    end

    // Bin stage, then factor stage
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_hi  <= w_hi;
            r_mid <= w_mid;
            r_idx <= w_idx;
        end
        if (r_v1) begin
            priority if (r_hi) begin
                r_factor <= FACTOR_TWO;
            end else if (r_mid) begin
                r_factor <= f_erf_entry(r_idx);
            end else begin
                r_factor <= '0;
            end
        end
    end

    assign o_done   = r_v2;
    assign o_factor = r_factor;

endmodule

@@ sv/erf_smoothed_box_profile.sv @@
// Load item: one 32-bit pass of the bit-serial multiplier (none for an index above the limit).
// Evaluate item: a 12-bit position pass, then for each box a 16-bit and an 18-bit pass
// of the bit-serial multiplier plus the erf lookup, then the result register.
// One item is worked on at a time; a finished result waits in the output register.
// Reset (synchronous, active low) restores the register defaults and clears the
// superphase level; the box parameter and step stores hold nothing until loaded.
module erf_smoothed_box_profile #(
    parameter int MAX_BOXES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_mode,
    input  logic [4:0]         i_param_index,
    input  logic signed [31:0] i_param_value,
    input  logic [11:0]        i_point_index,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [11:0]        o_point_out,
    output logic signed [47:0] o_density,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);
    import erfsb_pkg::*;

    localparam int KW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int NW = $clog2(MAX_BOXES + 1);
    localparam int PW = (MAX_BOXES > 0) ? $clog2(MAX_BOXES + 1) : 1;

    t_state r_state;
    t_state n_state;

    logic signed [31:0] r_scale;
    logic [15:0]        r_inv;
    logic [4:0]         r_bcnt;
    logic [15:0]        r_psp;
    logic [23:0]        r_loff;
    logic [23:0]        r_bsp;

    logic signed [31:0] r_param [MAX_BOXES+1];
    logic signed [47:0] r_step  [MAX_BOXES];
    logic signed [47:0] r_super;

    logic [4:0]         r_pidx;
    logic signed [31:0] r_val;
    logic [11:0]        r_pt;
    logic [NW-1:0]      r_n;
    logic [NW-1:0]      r_k;
    logic signed [29:0] r_d;
    logic signed [55:0] r_sum;

    logic               r_ov;
    logic [11:0]        r_opt;
    logic signed [47:0] r_dens;

    logic                     w_acc;
    logic                     w_ld_ok;
    logic [NW-1:0]            w_n;
    logic                     w_last;
    logic signed [32:0]       w_diff;
    logic signed [31:0]       w_prev;
    logic signed [56:0]       w_dbl;
    logic signed [47:0]       w_sat;
    t_mul_req                 w_req;
    logic                     w_mul_done;
    logic signed [MUL_PW-1:0] w_prod;
    logic                     w_erf_start;
    logic                     w_erf_done;
    logic [17:0]              w_factor;

    assign o_stall = (r_state != ST_IDLE);
    assign w_acc   = i_valid && !o_stall;
    assign w_ld_ok = (int'(r_pidx) <= MAX_BOXES);
    assign w_n     = (int'(r_bcnt) > MAX_BOXES) ? NW'(MAX_BOXES) : NW'(r_bcnt);
    assign w_last  = ((r_k + NW'(1)) == r_n);
    assign w_prev  = r_param[PW'(r_pidx - 5'd1)];
    assign w_diff  = (r_pidx == 5'd0) ? 33'(r_val) : (33'(r_val) - 33'(w_prev));

    // Double and clamp to the signed 48-bit range
    assign w_dbl = {r_sum, 1'b0};
    assign w_sat = (w_dbl[56:47] == {10{w_dbl[56]}}) ? w_dbl[47:0]
                 : (w_dbl[56] ? {1'b1, {47{1'b0}}} : {1'b0, {47{1'b1}}});

    erfsb_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    assign w_erf_start = (r_state == ST_T_WAIT) && w_mul_done;

    erfsb_erf u_erf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_erf_start),
        .i_t      (w_prod[45:0]),
        .o_done   (w_erf_done),
        .o_factor (w_factor)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (w_acc) n_state = i_mode ? ST_POS_GO : ST_LD_GO;
            ST_LD_GO:     n_state = w_ld_ok ? ST_LD_WAIT : ST_IDLE;
            ST_LD_WAIT:   if (w_mul_done) n_state = ST_IDLE;
            ST_POS_GO:    n_state = ST_POS_WAIT;
            ST_POS_WAIT:  if (w_mul_done) n_state = (r_n == '0) ? ST_DONE : ST_T_GO;
            ST_T_GO:      n_state = ST_T_WAIT;
            ST_T_WAIT:    if (w_mul_done) n_state = ST_ERF_WAIT;
            ST_ERF_WAIT:  if (w_erf_done) n_state = ST_TERM_GO;
            ST_TERM_GO:   n_state = ST_TERM_WAIT;
            ST_TERM_WAIT: if (w_mul_done) n_state = w_last ? ST_DONE : ST_T_GO;
            ST_DONE:      if (!r_ov || !i_stall) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // Multiplier requests
    always_comb begin
        w_req = '0;
        unique case (r_state)
            ST_LD_GO: begin
                w_req.start    = w_ld_ok;
                w_req.a        = 48'(w_diff);
                w_req.b        = r_scale;
                w_req.nbits    = 6'd32;
                w_req.b_signed = 1'b1;
            end
            ST_POS_GO: begin
                w_req.start = 1'b1;
                w_req.a     = 48'(r_psp);
                w_req.b     = 32'(r_pt);
                w_req.nbits = 6'd12;
            end
            ST_T_GO: begin
                w_req.start = 1'b1;
                w_req.a     = 48'(r_d);
                w_req.b     = 32'(r_inv);
                w_req.nbits = 6'd16;
            end
            ST_TERM_GO: begin
                w_req.start = 1'b1;
                w_req.a     = r_step[r_k[KW-1:0]];
                w_req.b     = 32'(w_factor);
                w_req.nbits = 6'd18;
            end
            default: w_req = '0;
        endcase
    end

    // State, configuration, superphase level and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_scale <= 32'sd65536;
            r_inv   <= 16'd256;
            r_bcnt  <= 5'd1;
            r_psp   <= 16'd85;
            r_loff  <= '0;
            r_bsp   <= 24'd256;
            r_super <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_SCALE:   r_scale <= i_cfg_data;
                    REG_INV_R:   r_inv   <= i_cfg_data[15:0];
                    REG_BCOUNT:  r_bcnt  <= i_cfg_data[4:0];
                    REG_PSPACE:  r_psp   <= i_cfg_data[15:0];
                    REG_LOFFSET: r_loff  <= i_cfg_data[23:0];
                    REG_BSPACE:  r_bsp   <= i_cfg_data[23:0];
                    default: ;
                endcase
            end
            if (r_state == ST_LD_WAIT && w_mul_done && r_pidx == 5'd0) begin
                r_super <= w_prod[63:16];
            end
            if (r_state == ST_DONE && (!r_ov || !i_stall)) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Item capture, stores and box accumulation
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_pidx <= i_param_index;
            r_val  <= i_param_value;
            r_pt   <= i_point_index;
            r_n    <= w_n;
        end
        if (r_state == ST_LD_WAIT && w_mul_done) begin
            if (r_pidx != 5'd0) begin
                r_step[KW'(r_pidx - 5'd1)] <= w_prod[64:17];
            end
            r_param[PW'(r_pidx)] <= r_val;
        end
        if (r_state == ST_POS_WAIT && w_mul_done) begin
            r_d   <= 30'(w_prod[28:0]) - 30'(r_loff);
            r_sum <= 56'(r_super);
            r_k   <= '0;
        end
        if (r_state == ST_TERM_WAIT && w_mul_done) begin
            r_sum <= r_sum + 56'($signed(w_prod[65:16]));
            r_d   <= r_d - 30'(r_bsp);
            r_k   <= r_k + NW'(1);
        end
        if (r_state == ST_DONE && (!r_ov || !i_stall)) begin
            r_opt  <= r_pt;
            r_dens <= w_sat;
        end
    end

    assign o_valid     = r_ov;
    assign o_point_out = r_opt;
    assign o_density   = r_dens;

endmodule

@@ sv/erfsb_chk.sv @@
module erfsb_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic [11:0]        o_point_out,
    input logic signed [47:0] o_density
);

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_density) && $stable(o_point_out))
        else $error("stalled result changed");

    // Drop the result after reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Go busy after every accepted item
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("not busy after accepting an item");

    // A new result only follows a busy period
    a_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared without work");

endmodule

bind erf_smoothed_box_profile erfsb_chk u_chk (.*);

@@ tb/erfsb_checker.sv @@
module erfsb_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_in_stall,
    input  logic               i_mode,
    input  logic [4:0]         i_param_index,
    input  logic signed [31:0] i_param_value,
    input  logic [11:0]        i_point_index,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [11:0]        i_point_out,
    input  logic signed [47:0] i_density,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import erfsb_pkg::*;

    localparam int  BOXES = 16;
    localparam int  TBL_DEPTH = 1024;
    localparam longint SIX = 393216;
    localparam longint D48_MAX = 64'sd140737488355327;
    localparam longint D48_MIN = -64'sd140737488355328;

    localparam longint KNOT [25] = '{
        0, 18109, 34111, 46606, 55227, 60483, 63315, 64663, 65229,
        65440, 65509, 65529, 65535, 65536, 65536, 65536, 65536, 65536,
        65536, 65536, 65536, 65536, 65536, 65536, 65536
    };

    typedef struct {
        logic [11:0]        point;
        logic signed [47:0] density;
    } t_point_result;

    t_point_result density_q[$];

    // Own copy of the registers and stores
    logic signed [31:0] scale_r;
    logic [15:0]        inv_rough_r;
    logic [4:0]         box_count_r;
    logic [15:0]        pt_space_r;
    logic [23:0]        left_off_r;
    logic [23:0]        box_space_r;
    logic signed [31:0] param_mem [BOXES+1];
    logic signed [47:0] step_mem [BOXES];
    logic signed [47:0] super_lvl;
    longint             one_erf [TBL_DEPTH];

    // Fill the one-plus-erf table from the quarter-step knots
    initial begin
        longint xq, ax, ki, fr, e;
        for (int j = 0; j < TBL_DEPTH; j++) begin
            xq = -SIX + ((2 * j + 1) * SIX) / TBL_DEPTH;
            ax = (xq < 0) ? -xq : xq;
            ki = ax >> 14;
            fr = ax & 16383;
            if (ki >= 24) e = KNOT[24];
            else e = KNOT[ki] + (((KNOT[ki+1] - KNOT[ki]) * fr) >> 14);
            one_erf[j] = (xq < 0) ? 65536 - e : 65536 + e;
        end
    end

    function automatic logic signed [47:0] profile_density(input logic [11:0] pt);
        longint             n, pos, t, ti;
        logic signed [95:0] acc, sv, ev;
        n   = (box_count_r > BOXES) ? BOXES : box_count_r;
        pos = longint'(pt) * longint'(pt_space_r) - longint'(left_off_r);
        acc = super_lvl;
        for (longint k = 0; k < n; k++) begin
            t  = (pos - k * longint'(box_space_r)) * longint'(inv_rough_r);
            sv = step_mem[k];
            if (t > SIX) begin
                acc = acc + sv * 2;
            end else if (t > -SIX) begin
                ti = ((t + SIX) * TBL_DEPTH) / (2 * SIX);
                if (ti >= TBL_DEPTH) ti = TBL_DEPTH - 1;
                ev = one_erf[ti];
                acc = acc + ((sv * ev) >>> 16);
            end
        end
        acc = acc * 2;
        if (acc > D48_MAX) acc = D48_MAX;
        if (acc < D48_MIN) acc = D48_MIN;
        return acc[47:0];
    endfunction

    always @(posedge i_clk) begin
        t_point_result      got, want;
        logic signed [95:0] diff, prod;
        if (!i_rst_n) begin
            scale_r     = 32'sd65536;
            inv_rough_r = 16'd256;
            box_count_r = 5'd1;
            pt_space_r  = 16'd85;
            left_off_r  = 24'd0;
            box_space_r = 24'd256;
            super_lvl   = '0;
            foreach (param_mem[i]) param_mem[i] = '0;
            foreach (step_mem[i]) step_mem[i] = '0;
            density_q.delete();
        end else begin
            // Register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SCALE:   scale_r     = i_cfg_data;
                    REG_INV_R:   inv_rough_r = i_cfg_data[15:0];
                    REG_BCOUNT:  box_count_r = i_cfg_data[4:0];
                    REG_PSPACE:  pt_space_r  = i_cfg_data[15:0];
                    REG_LOFFSET: left_off_r  = i_cfg_data[23:0];
                    REG_BSPACE:  box_space_r = i_cfg_data[23:0];
                    default: ;
                endcase
            end
            // Compare each result with the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                got.point   = i_point_out;
                got.density = i_density;
                if (density_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("Unexpected result: point %0d density %0d",
                                 got.point, got.density);
                end else begin
                    want = density_q.pop_front();
                    if (got.point !== want.point || got.density !== want.density) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("Mismatch: point exp %0d got %0d, density exp %0d got %0d",
                                     want.point, got.point, want.density, got.density);
                    end
                end
            end
            // Predict each accepted item
            if (i_valid && !i_in_stall) begin
                if (i_mode) begin
                    want.point   = i_point_index;
                    want.density = profile_density(i_point_index);
                    density_q.push_back(want);
                end else if (i_param_index <= BOXES) begin
                    if (i_param_index == 0) begin
                        prod = 96'(scale_r) * 96'(i_param_value);
                        super_lvl = 48'(prod >>> 16);
                    end else begin
                        diff = 96'(i_param_value) - 96'(param_mem[i_param_index-1]);
                        prod = 96'(scale_r) * diff;
                        step_mem[i_param_index-1] = 48'(prod >>> 17);
                    end
                    param_mem[i_param_index] = i_param_value;
                end
            end
        end
        o_pending = density_q.size();
    end

endmodule

@@ tb/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import erfsb_pkg::*;

    // Longest evaluate covers sixteen boxes; load is one multiplier pass
    localparam int SETTLE = 800;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic               i_mode;
    logic [4:0]         i_param_index;
    logic signed [31:0] i_param_value;
    logic [11:0]        i_point_index;
    logic               o_valid;
    logic               i_stall;
    logic [11:0]        o_point_out;
    logic signed [47:0] o_density;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_idx;
    logic [31:0]        i_cfg_data;
    int                 fail_count;
    int                 pending;
    int                 n_loads, n_evals, n_settings;

    erf_smoothed_box_profile DUT (.*);

    erfsb_checker u_checker (
        .i_clk, .i_rst_n, .i_valid,
        .i_in_stall(o_stall),
        .i_mode, .i_param_index, .i_param_value, .i_point_index,
        .i_out_valid(o_valid),
        .i_out_stall(i_stall),
        .i_point_out(o_point_out),
        .i_density(o_density),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_fail_count(fail_count),
        .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard limit on the run
    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    // Result side back-pressure: quiet stretches, short and occasional long stalls
    initial begin
        int quiet, len;
        i_stall = 0;
        forever begin
            quiet = $urandom_range(1, 60);
            repeat (quiet) @(negedge i_clk) i_stall = 0;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
            repeat (len) @(negedge i_clk) i_stall = 1;
        end
    end

    // Present one item and hold it until taken, then sometimes idle a while
    task automatic send_item(input logic mode, input logic [4:0] pidx,
                             input logic [31:0] pval, input logic [11:0] pt);
        int r;
        i_mode = mode;
        i_param_index = pidx;
        i_param_value = pval;
        i_point_index = pt;
        i_valid = 1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        if (mode) n_evals++;
        else n_loads++;
        r = $urandom_range(0, 9);
        if (r >= 6) begin
            i_valid = 0;
            repeat ((r < 9) ? $urandom_range(1, 3) : $urandom_range(10, 60)) @(negedge i_clk);
        end
    endtask

    // Hold off until every result is in and the block has gone quiet
    task automatic drain;
        i_valid = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_we = 1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    task automatic set_all(input logic [31:0] sc, input logic [15:0] ir, input logic [4:0] bc,
                           input logic [15:0] ps, input logic [23:0] lo, input logic [23:0] bs);
        write_reg(REG_SCALE, sc);
        write_reg(REG_INV_R, 32'(ir));
        write_reg(REG_BCOUNT, 32'(bc));
        write_reg(REG_PSPACE, 32'(ps));
        write_reg(REG_LOFFSET, 32'(lo));
        write_reg(REG_BSPACE, 32'(bs));
        n_settings++;
    endtask

    function automatic logic [31:0] pick_value;
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return 32'(int'($urandom_range(0, 262144)) - 131072);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [4:0] bc;
        i_rst_n = 0;
        i_valid = 0;
        i_mode = 0;
        i_param_index = 0;
        i_param_value = 0;
        i_point_index = 0;
        i_cfg_we = 0;
        i_cfg_idx = 0;
        i_cfg_data = 0;
        n_loads = 0;
        n_evals = 0;
        n_settings = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // Load every box parameter in order, extremes included, at reset settings
        for (int i = 0; i <= 16; i++)
            send_item(0, 5'(i), (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000, 0);
        send_item(0, 5'd31, 32'h1234_5678, 0);
        send_item(1, 0, 0, 12'd0);
        send_item(1, 0, 0, 12'd4095);
        drain();

        // Saturation: full scale with all sixteen boxes
        set_all(32'h7FFF_FFFF, 16'd1, 5'd16, 16'd65535, 24'd0, 24'd1);
        send_item(1, 0, 0, 12'd0);
        send_item(1, 0, 0, 12'd4095);
        drain();
        // Zero roughness, box count above the limit
        set_all(32'h8000_0000, 16'd0, 5'd31, 16'd1, 24'hFF_FFFF, 24'hFF_FFFF);
        send_item(1, 0, 0, 12'd1);
        send_item(1, 0, 0, 12'd4095);
        drain();
        // No boxes at all
        set_all(32'd65536, 16'hFFFF, 5'd0, 16'd85, 24'd0, 24'd256);
        send_item(1, 0, 0, 12'd100);
        drain();

        // Random phases of mostly short box rows
        for (int ph = 0; ph < 8; ph++) begin
            case ($urandom_range(0, 9))
                0: bc = 5'd16;
                1: bc = 5'($urandom_range(17, 31));
                2: bc = 5'd0;
                default: bc = 5'($urandom_range(1, 4));
            endcase
            set_all(($urandom_range(0, 1)) ? $urandom : 32'($urandom_range(0, 262144)),
                    ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 2048)),
                    bc,
                    ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 400)),
                    ($urandom_range(0, 1)) ? 24'($urandom) : 24'($urandom_range(0, 20000)),
                    ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(1, 4000)));
            for (int it = 0; it < 160; it++) begin
                if ($urandom_range(0, 3) == 0) begin
                    send_item(0, ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
                                                             : 5'($urandom_range(0, 16)),
                              pick_value(), 12'($urandom));
                end else begin
                    send_item(1, 5'($urandom), $urandom, 12'($urandom));
                end
            end
            drain();
        end

        $display("Covered %0d parameter loads and %0d point evaluations over %0d settings,",
                 n_loads, n_evals, n_settings);
        $display("with random gaps and back-pressure on both channels.");
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/erfsb_pkg.sv
sv/erfsb_mul.sv
sv/erfsb_erf.sv
sv/erf_smoothed_box_profile.sv
sv/erfsb_chk.sv
tb/erfsb_checker.sv
tb/tb_top.sv
